/* rtl/gmc_pkg.sv */
// Shared constants, codes and interface structs of the grid move collision clip block.
package gmc_pkg;

    localparam int MAX_CELLS_X = 256;
    localparam int MAX_CELLS_Y = 256;
    localparam int MAP_PITCH   = 256;
    localparam int PITCH_W     = $clog2(MAP_PITCH);
    localparam int MAP_AW      = 2 * PITCH_W;
    localparam int MAP_DEPTH   = MAP_PITCH * MAP_PITCH;

    localparam int CELL_LIM_X = (MAX_CELLS_X < MAP_PITCH) ? MAX_CELLS_X : MAP_PITCH;
    localparam int CELL_LIM_Y = (MAX_CELLS_Y < MAP_PITCH) ? MAX_CELLS_Y : MAP_PITCH;

    localparam int GRID_W   = 9;   // cells_x / cells_y register width
    localparam int PX_W     = 16;  // clamped pixel width
    localparam int FRAC_W   = 16;  // Q16.16 fraction bits
    localparam int POS_W    = PX_W + FRAC_W;
    localparam int COORD_W  = 18;  // signed pixel field width
    localparam int CSIZE_W  = 8;   // cell size width
    localparam int STEP_W   = POS_W - FRAC_W + 1;  // step count width
    localparam int WALK_W   = PITCH_W + FRAC_W;    // position bits inside the grid

    localparam int DIV_NUM_W = POS_W;
    localparam int DIV_DEN_W = STEP_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAP_PRESENT = 3'd0,
        CFG_MAP_WIDTH   = 3'd1,
        CFG_MAP_HEIGHT  = 3'd2,
        CFG_CELLS_X     = 3'd3,
        CFG_CELLS_Y     = 3'd4,
        CFG_CELL_W      = 3'd5,
        CFG_CELL_H      = 3'd6
    } cfg_idx_t;

    localparam logic CMD_QUERY = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef struct packed {
        logic              wr_en;
        logic [MAP_AW-1:0] wr_addr;
        logic              wr_data;
        logic              rd_en;
        logic [MAP_AW-1:0] rd_addr;
    } map_req_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
    } div_rsp_t;

endpackage

/* rtl/grid_move_collision_clip.sv */
// Top level: grid move collision check with a blocked-cell map and a line walk.
//
// Usage notes:
// - s_ channel takes words: tuser = cmd (0 query, 1 map write); tdata carries
//   start/target pixels, cell index and blocked bit. Map writes give no result.
// - m_ channel gives one word per query: fixed_x, fixed_y, move_ok.
// - cfg channel writes the seven setup registers by index; always ready.
//   Write setup only while the block is idle.
// - After reset the map is swept clear, one cell per cycle, all 65536 cells;
//   s_tready stays low until the sweep is done. Setup writes are taken anyway.
// - A map write is done at accept. A query takes six divisions on the
//   shared divider plus a step state and a check state per walk step, the
//   step state issuing the map read; a walk has up to one step per cell crossed.
//   A query that stays in its start cell ends after the first four divisions;
//   one that finds no map ends at once.
// - Results sit in an output register; the next word is accepted while a
//   result waits. When a result waits and m_tready is low, a finished query
//   waits in its done state until the output register frees up.
module grid_move_collision_clip (
    input  logic        aclk,
    input  logic        aresetn,
    // tdata: start_x[17:0], start_y[35:18], target_x[53:36], target_y[71:54],
    //        cell_index[87:72], cell_blocked[88], zero fill
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,
    input  logic        s_tuser,     // tuser: cmd
    // tdata: fixed_x[17:0], fixed_y[35:18], move_ok[36], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int PX_W   = gmc_pkg::PX_W;
    localparam int POS_W  = gmc_pkg::POS_W;
    localparam int FRAC_W = gmc_pkg::FRAC_W;
    localparam int STEP_W = gmc_pkg::STEP_W;
    localparam int CW_W   = gmc_pkg::CSIZE_W;
    localparam int GW     = gmc_pkg::GRID_W;
    localparam int XW     = gmc_pkg::COORD_W;
    localparam int PW     = gmc_pkg::PITCH_W;
    localparam int WW     = gmc_pkg::WALK_W;
    localparam int SW     = POS_W + 2;  // signed step / next position width

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_DIV_GO   = 9'b000000010,
        ST_DIV_WAIT = 9'b000000100,
        ST_SETUP    = 9'b000001000,
        ST_IGN      = 9'b000010000,
        ST_STEP     = 9'b000100000,
        ST_CHK      = 9'b001000000,
        ST_SCALE    = 9'b010000000,
        ST_DONE     = 9'b100000000
    } state_t;

    typedef enum logic [2:0] {
        DIV_SX = 3'd0,
        DIV_SY = 3'd1,
        DIV_TX = 3'd2,
        DIV_TY = 3'd3,
        DIV_DX = 3'd4,
        DIV_DY = 3'd5
    } div_sel_t;

    // Config registers
    logic            map_present_reg;
    logic [15:0]     map_w_reg, map_h_reg;
    logic [GW-1:0]   cells_x_reg, cells_y_reg;
    logic [CW_W-1:0] cell_w_reg, cell_h_reg;

    state_t   state_reg, state_next;
    div_sel_t sel_reg;

    logic [PX_W-1:0]   sx_reg, sy_reg, tx_reg, ty_reg;
    logic              ok_reg, moved_reg, ign_reg;
    logic [POS_W-1:0]  ux_reg, uy_reg, utx_reg, uty_reg;
    logic [POS_W:0]    dx_reg, dy_reg;
    logic [STEP_W-1:0] n_reg, i_reg;
    logic signed [SW-1:0] stx_reg, sty_reg, nx_reg, ny_reg;
    logic              ingrid_reg, ign_pitch_reg;
    logic [XW-1:0]     res_x_reg, res_y_reg;
    logic              res_ok_reg;
    logic              m_tvalid_reg;
    logic [39:0]       m_tdata_reg;

    gmc_pkg::map_req_t map_req;
    logic              map_rd_data, map_init_done;
    gmc_pkg::div_req_t div_req;
    gmc_pkg::div_rsp_t div_rsp;

    gmc_map_ram u_map (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (map_req),
        .rd_data   (map_rd_data),
        .init_done (map_init_done)
    );

    gmc_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Effective sizes: zero reads as one, grid limited to the store pitch
    logic [15:0]     w_eff, h_eff;
    logic [CW_W-1:0] cw_eff, ch_eff;
    logic [GW-1:0]   gx, gy;

    assign w_eff  = (map_w_reg == '0) ? 16'd1 : map_w_reg;
    assign h_eff  = (map_h_reg == '0) ? 16'd1 : map_h_reg;
    assign cw_eff = (cell_w_reg == '0) ? CW_W'(1) : cell_w_reg;
    assign ch_eff = (cell_h_reg == '0) ? CW_W'(1) : cell_h_reg;
    assign gx = (cells_x_reg > GW'(gmc_pkg::CELL_LIM_X)) ? GW'(gmc_pkg::CELL_LIM_X)
                                                         : cells_x_reg;
    assign gy = (cells_y_reg > GW'(gmc_pkg::CELL_LIM_Y)) ? GW'(gmc_pkg::CELL_LIM_Y)
                                                         : cells_y_reg;

    // {out_of_range, clamped value}
    function automatic logic [PX_W:0] clamp_px(input logic signed [XW-1:0] v,
                                               input logic [15:0] size);
        logic [PX_W:0] r;
        if (v[XW-1]) begin
            r = {1'b1, {PX_W{1'b0}}};
        end else if (v[XW-2:0] >= {1'b0, size}) begin
            r = {1'b1, size - 16'd1};
        end else begin
            r = {1'b0, v[PX_W-1:0]};
        end
        return r;
    endfunction

    logic signed [XW-1:0] in_sx, in_sy, in_tx, in_ty;
    logic [PX_W:0]        c_sx, c_sy, c_tx, c_ty;
    logic                 s_fire;

    assign in_sx  = s_tdata[17:0];
    assign in_sy  = s_tdata[35:18];
    assign in_tx  = s_tdata[53:36];
    assign in_ty  = s_tdata[71:54];
    assign c_sx   = clamp_px(in_sx, w_eff);
    assign c_sy   = clamp_px(in_sy, h_eff);
    assign c_tx   = clamp_px(in_tx, w_eff);
    assign c_ty   = clamp_px(in_ty, h_eff);
    assign s_tready = (state_reg == ST_IDLE) && map_init_done;
    assign s_fire   = s_tvalid && s_tready;

    // Setup arithmetic: distance, step count
    logic [POS_W:0]    dx_c, dy_c;
    logic [POS_W-1:0]  adx, ady;
    logic [STEP_W-1:0] cx_c, cy_c, n_c;
    logic              same_cell;
    logic [15:0]       start_col, start_row;

    assign dx_c = {1'b0, utx_reg} - {1'b0, ux_reg};
    assign dy_c = {1'b0, uty_reg} - {1'b0, uy_reg};
    assign adx  = dx_c[POS_W] ? POS_W'(-dx_c) : dx_c[POS_W-1:0];
    assign ady  = dy_c[POS_W] ? POS_W'(-dy_c) : dy_c[POS_W-1:0];
    assign cx_c = STEP_W'(({1'b0, adx} + (POS_W+1)'(16'hFFFF)) >> FRAC_W);
    assign cy_c = STEP_W'(({1'b0, ady} + (POS_W+1)'(16'hFFFF)) >> FRAC_W);
    always_comb begin
        n_c = STEP_W'(1);
        if (cx_c > n_c) n_c = cx_c;
        if (cy_c > n_c) n_c = cy_c;
    end
    assign same_cell = (ux_reg[POS_W-1:FRAC_W] == utx_reg[POS_W-1:FRAC_W]) &&
                       (uy_reg[POS_W-1:FRAC_W] == uty_reg[POS_W-1:FRAC_W]);
    assign start_col = ux_reg[POS_W-1:FRAC_W];
    assign start_row = uy_reg[POS_W-1:FRAC_W];

    // Walk arithmetic
    logic signed [SW-1:0] nx_c, ny_c;
    logic                 ingrid_c;
    logic [SW-2:0]        gx_lim, gy_lim;
    logic [2*CW_W+WW-1:0] sc_x, sc_y;

    assign nx_c   = $signed({2'b00, ux_reg}) + stx_reg;
    assign ny_c   = $signed({2'b00, uy_reg}) + sty_reg;
    assign gx_lim = (SW-1)'({gx, {FRAC_W{1'b0}}});
    assign gy_lim = (SW-1)'({gy, {FRAC_W{1'b0}}});
    assign ingrid_c = !nx_c[SW-1] && (nx_c[SW-2:0] < gx_lim) &&
                      !ny_c[SW-1] && (ny_c[SW-2:0] < gy_lim);
    assign sc_x = (2*CW_W+WW)'(ux_reg[WW-1:0] * cw_eff);
    assign sc_y = (2*CW_W+WW)'(uy_reg[WW-1:0] * ch_eff);

    logic blocked_hit;
    assign blocked_hit = !ingrid_reg || (!ign_reg && map_rd_data);

    // Divider operand select
    always_comb begin
        div_req.start = (state_reg == ST_DIV_GO);
        div_req.num   = '0;
        div_req.den   = '0;
        unique case (sel_reg)
            DIV_SX: begin
                div_req.num = {sx_reg, {FRAC_W{1'b0}}};
                div_req.den = STEP_W'(cw_eff);
            end
            DIV_SY: begin
                div_req.num = {sy_reg, {FRAC_W{1'b0}}};
                div_req.den = STEP_W'(ch_eff);
            end
            DIV_TX: begin
                div_req.num = {tx_reg, {FRAC_W{1'b0}}};
                div_req.den = STEP_W'(cw_eff);
            end
            DIV_TY: begin
                div_req.num = {ty_reg, {FRAC_W{1'b0}}};
                div_req.den = STEP_W'(ch_eff);
            end
            DIV_DX: begin
                div_req.num = dx_reg[POS_W] ? POS_W'(-dx_reg) : dx_reg[POS_W-1:0];
                div_req.den = n_reg;
            end
            DIV_DY: begin
                div_req.num = dy_reg[POS_W] ? POS_W'(-dy_reg) : dy_reg[POS_W-1:0];
                div_req.den = n_reg;
            end
            default: begin
                div_req.num = '0;
                div_req.den = STEP_W'(1);
            end
        endcase
    end

    // Map port: writes at accept, reads for start cell and each step
    always_comb begin
        map_req.wr_en   = s_fire && (s_tuser == gmc_pkg::CMD_WRITE);
        map_req.wr_addr = s_tdata[87:72];
        map_req.wr_data = s_tdata[88];
        map_req.rd_en   = (state_reg == ST_SETUP) || (state_reg == ST_STEP);
        if (state_reg == ST_SETUP) begin
            map_req.rd_addr = {start_row[PW-1:0], start_col[PW-1:0]};
        end else begin
            map_req.rd_addr = {ny_c[FRAC_W+PW-1:FRAC_W], nx_c[FRAC_W+PW-1:FRAC_W]};
        end
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && (s_tuser == gmc_pkg::CMD_QUERY)) begin
                    state_next = map_present_reg ? ST_DIV_GO : ST_DONE;
                end
            end
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    priority if (sel_reg == DIV_TY) state_next = ST_SETUP;
                    else if (sel_reg == DIV_DY)     state_next = ST_STEP;
                    else                            state_next = ST_DIV_GO;
                end
            end
            ST_SETUP: state_next = same_cell ? ST_DONE : ST_IGN;
            ST_IGN:   state_next = ST_DIV_GO;
            ST_STEP: begin
                priority if (!ok_reg)     state_next = ST_DONE;
                else if (i_reg == n_reg)  state_next = ST_DONE;
                else                      state_next = ST_CHK;
            end
            ST_CHK: begin
                if (blocked_hit) state_next = moved_reg ? ST_SCALE : ST_DONE;
                else             state_next = ST_STEP;
            end
            ST_SCALE: state_next = ST_DONE;
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_tvalid_reg    <= 1'b0;
            map_present_reg <= 1'b0;
            map_w_reg       <= 16'd4096;
            map_h_reg       <= 16'd4096;
            cells_x_reg     <= GW'(256);
            cells_y_reg     <= GW'(256);
            cell_w_reg      <= CW_W'(16);
            cell_h_reg      <= CW_W'(16);
        end else begin
            state_reg <= state_next;
            if ((state_reg == ST_DONE) && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                unique case (cfg_index)
                    gmc_pkg::CFG_MAP_PRESENT: map_present_reg <= cfg_data[0];
                    gmc_pkg::CFG_MAP_WIDTH:   map_w_reg       <= cfg_data;
                    gmc_pkg::CFG_MAP_HEIGHT:  map_h_reg       <= cfg_data;
                    gmc_pkg::CFG_CELLS_X:     cells_x_reg     <= cfg_data[GW-1:0];
                    gmc_pkg::CFG_CELLS_Y:     cells_y_reg     <= cfg_data[GW-1:0];
                    gmc_pkg::CFG_CELL_W:      cell_w_reg      <= cfg_data[CW_W-1:0];
                    gmc_pkg::CFG_CELL_H:      cell_h_reg      <= cfg_data[CW_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                sel_reg   <= DIV_SX;
                moved_reg <= 1'b0;
                i_reg     <= '0;
                sx_reg    <= c_sx[PX_W-1:0];
                sy_reg    <= c_sy[PX_W-1:0];
                tx_reg    <= c_tx[PX_W-1:0];
                ty_reg    <= c_ty[PX_W-1:0];
                ok_reg    <= !(c_sx[PX_W] || c_sy[PX_W]) && !(c_tx[PX_W] && c_ty[PX_W]);
                // no map: echo the raw target
                res_x_reg  <= in_tx;
                res_y_reg  <= in_ty;
                res_ok_reg <= 1'b0;
            end
            ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    unique case (sel_reg)
                        DIV_SX: begin ux_reg  <= div_rsp.quo; sel_reg <= DIV_SY; end
                        DIV_SY: begin uy_reg  <= div_rsp.quo; sel_reg <= DIV_TX; end
                        DIV_TX: begin utx_reg <= div_rsp.quo; sel_reg <= DIV_TY; end
                        DIV_TY: begin uty_reg <= div_rsp.quo; sel_reg <= DIV_DX; end
                        DIV_DX: begin
                            stx_reg <= dx_reg[POS_W] ? -$signed({2'b00, div_rsp.quo})
                                                     :  $signed({2'b00, div_rsp.quo});
                            sel_reg <= DIV_DY;
                        end
                        DIV_DY: begin
                            sty_reg <= dy_reg[POS_W] ? -$signed({2'b00, div_rsp.quo})
                                                     :  $signed({2'b00, div_rsp.quo});
                        end
                        default: ;
                    endcase
                end
            end
            ST_SETUP: begin
                dx_reg        <= dx_c;
                dy_reg        <= dy_c;
                n_reg         <= n_c;
                ign_pitch_reg <= (start_col >= 16'(gmc_pkg::MAP_PITCH)) ||
                                 (start_row >= 16'(gmc_pkg::MAP_PITCH));
                res_x_reg     <= XW'(tx_reg);
                res_y_reg     <= XW'(ty_reg);
                res_ok_reg    <= ok_reg;
            end
            ST_IGN: begin
                ign_reg <= ign_pitch_reg || map_rd_data;
            end
            ST_STEP: begin
                nx_reg     <= nx_c;
                ny_reg     <= ny_c;
                ingrid_reg <= ingrid_c;
                i_reg      <= i_reg + 1'b1;
                if (!ok_reg) begin
                    res_x_reg  <= XW'(sx_reg);
                    res_y_reg  <= XW'(sy_reg);
                    res_ok_reg <= 1'b0;
                end else begin
                    res_x_reg  <= XW'(tx_reg);
                    res_y_reg  <= XW'(ty_reg);
                    res_ok_reg <= 1'b1;
                end
            end
            ST_CHK: begin
                if (blocked_hit) begin
                    ok_reg     <= 1'b0;
                    res_x_reg  <= XW'(sx_reg);
                    res_y_reg  <= XW'(sy_reg);
                    res_ok_reg <= 1'b0;
                end else begin
                    ux_reg    <= nx_reg[POS_W-1:0];
                    uy_reg    <= ny_reg[POS_W-1:0];
                    moved_reg <= 1'b1;
                end
            end
            ST_SCALE: begin
                res_x_reg <= XW'(sc_x[FRAC_W+PX_W-1:FRAC_W]);
                res_y_reg <= XW'(sc_y[FRAC_W+PX_W-1:FRAC_W]);
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_reg <= {3'b000, res_ok_reg, res_y_reg, res_x_reg};
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign cfg_ready = 1'b1;

    // No query may start while the map sweep runs
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !map_init_done |-> !s_tready)
        else $error("word accepted during map clear");

    // Step counter never passes the step count
    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STEP) |-> (i_reg <= n_reg))
        else $error("walk ran past its step count");

    // A moved point always lies inside the grid
    a_moved_in_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STEP) && moved_reg |->
            ({2'b00, ux_reg} < gx_lim) && ({2'b00, uy_reg} < gy_lim))
        else $error("walk position left the grid");

    // Divider result only arrives while waiting for it
    a_div_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider finished outside wait state");

endmodule

/* rtl/gmc_map_ram.sv */
// Blocked-cell map memory with a clearing sweep after reset.
module gmc_map_ram (
    input  logic                aclk,
    input  logic                aresetn,
    input  gmc_pkg::map_req_t   req,
    output logic                rd_data,
    output logic                init_done
);

    logic                       mem [gmc_pkg::MAP_DEPTH];
    logic                       clearing_reg;
    logic [gmc_pkg::MAP_AW-1:0] clr_addr_reg;
    logic                       rd_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clearing_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (&clr_addr_reg) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            mem[clr_addr_reg] <= 1'b0;
        end else if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data   = rd_data_reg;
    assign init_done = !clearing_reg;

endmodule

/* rtl/gmc_divider.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module gmc_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  gmc_pkg::div_req_t req,
    output gmc_pkg::div_rsp_t rsp
);

    localparam int NW = gmc_pkg::DIV_NUM_W;
    localparam int DW = gmc_pkg::DIV_DEN_W;
    localparam int CW = $clog2(NW);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] quo_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    assign trial = {rem_reg, quo_reg[NW-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(NW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg <= req.num;
            rem_reg <= '0;
            den_reg <= req.den;
        end else if (busy_reg) begin
            if (!diff[DW]) begin
                rem_reg <= diff[DW-1:0];
                quo_reg <= {quo_reg[NW-2:0], 1'b1};
            end else begin
                rem_reg <= trial[DW-1:0];
                quo_reg <= {quo_reg[NW-2:0], 1'b0};
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule
